@@ design/ip_literal_text_parser_defines.svh @@
// ----------------------------------------------------------------------------
// ip_literal_text_parser_defines.svh
// Assertion macros for the IP literal text parser.
// ----------------------------------------------------------------------------
`ifndef IP_LITERAL_TEXT_PARSER_DEFINES_SVH
`define IP_LITERAL_TEXT_PARSER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define ILTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ILTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/iltp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iltp_pkg
// Shared types, character codes and helpers for the IP literal text parser.
// ----------------------------------------------------------------------------
package iltp_pkg;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_BODY,
    MODE_BRACKET,
    MODE_IGNORE
  } mode_e;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  localparam int unsigned OCTET_MAX      = 255;
  localparam int unsigned DBL_GROUPS_MAX = 7;
  localparam logic [7:0]  BYTE_MASK      = 8'hFF;

  // One input character and its handshake flags as seen by the parser lanes.
  typedef struct packed {
    logic       accept;
    logic       last;
    logic       feed;
    logic [7:0] code;
  } step_t;

  typedef struct packed {
    logic        valid_res;
    logic        is_v6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;

  function automatic logic is_dec(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

@@ design/iltp_v4.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iltp_v4
// Dotted decimal lane: collects four octets, flags malformed text.
// ----------------------------------------------------------------------------
module iltp_v4 (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iltp_pkg::step_t step_i,
  output logic           ok_o,
  output logic [31:0]    addr_o
);
  import iltp_pkg::*;

  logic [2:0][7:0] bytes_q, bytes_d, bytes_f;
  logic [7:0]      octet_q, octet_d, octet_f;
  logic [1:0]      dcnt_q, dcnt_d, dcnt_f;
  logic [1:0]      pcnt_q, pcnt_d, pcnt_f;
  logic            bad_q, bad_d, bad_f;
  logic [11:0]     acc;

  // octet * 10 + digit
  assign acc = {1'b0, octet_q, 3'b000} + {3'b000, octet_q, 1'b0} + {8'h00, step_i.code[3:0]};

  always_comb begin
    bytes_f = bytes_q;
    octet_f = octet_q;
    dcnt_f  = dcnt_q;
    pcnt_f  = pcnt_q;
    bad_f   = bad_q;
    if (step_i.feed && !bad_q) begin
      if (step_i.code == CH_DOT) begin
        if (dcnt_q == 2'd0 || pcnt_q == 2'd3) begin
          bad_f = 1'b1;
        end else begin
          bytes_f[pcnt_q] = octet_q;
          pcnt_f          = pcnt_q + 2'd1;
          octet_f         = '0;
          dcnt_f          = '0;
        end
      end else if (is_dec(step_i.code)) begin
        if (dcnt_q == 2'd3 || acc > 12'(OCTET_MAX)) begin
          bad_f = 1'b1;
        end else begin
          dcnt_f  = dcnt_q + 2'd1;
          octet_f = acc[7:0] & BYTE_MASK;
        end
      end else begin
        bad_f = 1'b1;
      end
    end
  end

  assign ok_o   = !bad_f && (dcnt_f != 2'd0) && (pcnt_f == 2'd3);
  assign addr_o = {bytes_f[0], bytes_f[1], bytes_f[2], octet_f};

  always_comb begin
    if (step_i.accept && step_i.last) begin
      bytes_d = '0;
      octet_d = '0;
      dcnt_d  = '0;
      pcnt_d  = '0;
      bad_d   = 1'b0;
    end else begin
      bytes_d = bytes_f;
      octet_d = octet_f;
      dcnt_d  = dcnt_f;
      pcnt_d  = pcnt_f;
      bad_d   = bad_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= '0;
      octet_q <= '0;
      dcnt_q  <= '0;
      pcnt_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      bytes_q <= bytes_d;
      octet_q <= octet_d;
      dcnt_q  <= dcnt_d;
      pcnt_q  <= pcnt_d;
      bad_q   <= bad_d;
    end
  end

endmodule

@@ design/iltp_v6.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iltp_v6
// Colon hex lane: head and tail group stores, double colon expansion.
// ----------------------------------------------------------------------------
module iltp_v6 (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  iltp_pkg::step_t step_i,
  output logic            ok_o,
  output logic [127:0]    addr_o
);
  import iltp_pkg::*;

  typedef struct packed {
    logic [7:0][15:0] head;
    logic [7:0][15:0] tail;
    logic [15:0]      group;
    logic [2:0]       dcnt;
    logic [3:0]       hcnt;
    logic [2:0]       tcnt;
    logic             dbl;
    logic             prev;
    logic             lead;
    logic             bad;
  } v6_state_t;

  v6_state_t        s_q, s_d, s_f, s_fin;
  logic [7:0][15:0] words;

  function automatic v6_state_t close_grp(v6_state_t s);
    v6_state_t r;
    r = s;
    if (s.dbl) begin
      if ({2'b00, s.tcnt} + {1'b0, s.hcnt} >= 5'(DBL_GROUPS_MAX)) begin
        r.bad = 1'b1;
      end else begin
        r.tail[s.tcnt] = s.group;
        r.tcnt  = s.tcnt + 3'd1;
        r.group = '0;
        r.dcnt  = '0;
      end
    end else begin
      if (s.hcnt >= 4'd8) begin
        r.bad = 1'b1;
      end else begin
        r.head[s.hcnt[2:0]] = s.group;
        r.hcnt  = s.hcnt + 4'd1;
        r.group = '0;
        r.dcnt  = '0;
      end
    end
    return r;
  endfunction

  function automatic v6_state_t feed(v6_state_t s, logic [7:0] c);
    v6_state_t  r;
    logic [3:0] d;
    logic       hex;
    r   = s;
    hex = 1'b1;
    d   = '0;
    if (is_dec(c)) begin
      d = c[3:0];
    end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
      d = c[3:0] + 4'd9;
    end else begin
      hex = 1'b0;
    end
    if (c == CH_COLON) begin
      if (s.dcnt != 3'd0) begin
        r      = close_grp(s);
        r.prev = 1'b1;
      end else if (s.prev || s.lead) begin
        if (s.dbl || s.hcnt > 4'd7) begin
          r.bad = 1'b1;
        end else begin
          r.dbl  = 1'b1;
          r.prev = 1'b0;
          r.lead = 1'b0;
        end
      end else if (s.dbl) begin
        r.bad = 1'b1;
      end else begin
        r.lead = 1'b1;
      end
    end else if (!hex || s.lead || s.dcnt >= 3'd4) begin
      r.bad = 1'b1;
    end else begin
      r.group = {s.group[11:0], d};
      r.dcnt  = s.dcnt + 3'd1;
      r.prev  = 1'b0;
    end
    return r;
  endfunction

  assign s_f = (step_i.feed && !s_q.bad) ? feed(s_q, step_i.code) : s_q;

  // end of literal: flag a trailing colon, close an open group, then check the group count
  always_comb begin
    s_fin = s_f;
    if (!s_fin.bad && (s_fin.lead || s_fin.prev)) begin
      s_fin.bad = 1'b1;
    end
    if (!s_fin.bad && s_fin.dcnt != 3'd0) begin
      s_fin = close_grp(s_fin);
    end
    if (!s_fin.bad && !s_fin.dbl && s_fin.hcnt != 4'd8) begin
      s_fin.bad = 1'b1;
    end
  end

  // tail groups are right-aligned behind the head groups
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      words[7-j] = '0;
      if (4'(j) < s_fin.hcnt) begin
        words[7-j] = s_fin.head[j];
      end
      if (4'(j) + {1'b0, s_fin.tcnt} >= 4'd8) begin
        words[7-j] = s_fin.tail[3'(3'(j) + s_fin.tcnt)];
      end
    end
  end

  assign ok_o   = !s_fin.bad;
  assign addr_o = words;

  assign s_d = (step_i.accept && step_i.last) ? v6_state_t'('0) : s_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else begin
      s_q <= s_d;
    end
  end

endmodule

@@ design/iltp_res.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iltp_res
// Result register with valid/ready output handshake.
// ----------------------------------------------------------------------------
module iltp_res (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  iltp_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              space_o,
  output logic              valid_res_o,
  output logic              is_v6_o,
  output logic [63:0]       addr_high_o,
  output logic [63:0]       addr_low_o
);
  import iltp_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign space_o = !vld_q || out_ready_i;
  assign vld_d   = load_i || (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign valid_res_o = res_q.valid_res;
  assign is_v6_o     = res_q.is_v6;
  assign addr_high_o = res_q.addr_high;
  assign addr_low_o  = res_q.addr_low;

endmodule

@@ design/ip_literal_text_parser.sv @@
`timescale 1ns / 1ps
// The result of a literal is registered and on the output in the cycle after its last character.
// Throughput: one character per cycle while input ready is high; lane state updates on each character.
// A new literal may start in the cycle after a last character, no gap, if the output takes the result.
// Input ready drops only while a finished result is held by the output register and out_ready_i is low.
// Reset: asynchronous, active low; clears all parser state and the result valid.
`include "ip_literal_text_parser_defines.svh"
// ----------------------------------------------------------------------------
// ip_literal_text_parser
// Character stream parser for IPv4 and IPv6 address literals.
// ----------------------------------------------------------------------------
module ip_literal_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic        is_v6_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o
);
  import iltp_pkg::*;

  // Framing state: where we are in the literal (bracket, zone suffix etc.)
  mode_e        mode_q, mode_d;
  logic         zone_q, zone_d;     // inside "[...%zone]"
  logic         saw_any_q, saw_any_d;
  logic         saw_colon_q, saw_colon_d;
  logic         space;
  logic         accept;
  logic         feed_en;
  step_t        step;
  logic         v4_ok, v6_ok;
  logic [31:0]  v4_addr;
  logic [127:0] v6_addr;
  logic         lit_ok;
  result_t      res;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  // Next framing state
  always_comb begin
    mode_d = mode_q;
    zone_d = zone_q;
    unique case (mode_q)
      MODE_START: begin
        if (char_code_i == CH_LBRACK) begin
          mode_d = MODE_BRACKET;
        end else if (char_code_i == CH_PCT) begin
          mode_d = MODE_IGNORE;
        end else begin
          mode_d = MODE_BODY;
        end
      end
      MODE_BODY: begin
        if (char_code_i == CH_PCT) begin
          mode_d = MODE_IGNORE;
        end
      end
      MODE_BRACKET: begin
        if (char_code_i == CH_RBRACK) begin
          mode_d = MODE_IGNORE;
          zone_d = 1'b0;
        end else if (!zone_q && char_code_i == CH_PCT) begin
          zone_d = 1'b1;
        end
      end
      MODE_IGNORE: begin
        mode_d = MODE_IGNORE;
      end
      default: begin
        mode_d = MODE_IGNORE;
      end
    endcase
  end

  // Whether the character is part of the kept address text
  always_comb begin
    feed_en = 1'b0;
    unique case (mode_q)
      MODE_START:   feed_en = (char_code_i != CH_LBRACK) && (char_code_i != CH_PCT);
      MODE_BODY:    feed_en = (char_code_i != CH_PCT);
      MODE_BRACKET: feed_en = (char_code_i != CH_RBRACK) && !zone_q &&
                              (char_code_i != CH_PCT);
      MODE_IGNORE:  feed_en = 1'b0;
      default:      feed_en = 1'b0;
    endcase
  end

  assign step.accept = accept;
  assign step.last   = last_char_i;
  assign step.feed   = accept && feed_en;
  assign step.code   = char_code_i;

  assign saw_any_d   = saw_any_q || step.feed;
  assign saw_colon_d = saw_colon_q || (step.feed && char_code_i == CH_COLON);

  // Framing registers; everything returns to the start state after a last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_START;
      zone_q      <= 1'b0;
      saw_any_q   <= 1'b0;
      saw_colon_q <= 1'b0;
    end else if (accept) begin
      if (last_char_i) begin
        mode_q      <= MODE_START;
        zone_q      <= 1'b0;
        saw_any_q   <= 1'b0;
        saw_colon_q <= 1'b0;
      end else begin
        mode_q      <= mode_d;
        zone_q      <= zone_d;
        saw_any_q   <= saw_any_d;
        saw_colon_q <= saw_colon_d;
      end
    end
  end

  // Both lanes parse the kept text side by side; a colon anywhere in the kept text picks IPv6.
  iltp_v4 u_v4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ok_o   (v4_ok),
    .addr_o (v4_addr)
  );

  iltp_v6 u_v6 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ok_o   (v6_ok),
    .addr_o (v6_addr)
  );

  // Unclosed bracket or empty text is always invalid; addresses zeroed when invalid.
  assign lit_ok = (mode_d != MODE_BRACKET) && saw_any_d && (saw_colon_d ? v6_ok : v4_ok);

  always_comb begin
    res.valid_res = lit_ok;
    res.is_v6     = saw_colon_d;
    res.addr_high = '0;
    res.addr_low  = '0;
    if (lit_ok) begin
      if (saw_colon_d) begin
        res.addr_high = v6_addr[127:64];
        res.addr_low  = v6_addr[63:0];
      end else begin
        res.addr_low  = {32'h0000_0000, v4_addr};
      end
    end
  end

  iltp_res u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && last_char_i),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .space_o     (space),
    .valid_res_o (valid_res_o),
    .is_v6_o     (is_v6_o),
    .addr_high_o (addr_high_o),
    .addr_low_o  (addr_low_o)
  );

  `ILTP_ASSERT(a_res_follows_last, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_char_i), "result without a last character")
  `ILTP_ASSERT(a_last_gives_res, in_valid_i && in_ready_o && last_char_i |=> out_valid_o, "last character gave no result")
  `ILTP_ASSERT(a_invalid_zero, out_valid_o && !valid_res_o |-> addr_high_o == 64'h0 && addr_low_o == 64'h0, "invalid result carries an address")
  `ILTP_ASSERT(a_v4_range, out_valid_o && valid_res_o && !is_v6_o |-> addr_high_o == 64'h0 && addr_low_o[63:32] == 32'h0, "IPv4 result outside low 32 bits")

endmodule
